/* src/mrf_pkg.sv */
// Shared types, codes and the CRC step for the Modbus RTU request framer.
`timescale 1ns / 1ps
`default_nettype none
package mrf_pkg;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_DATA  = 2'd2;

    localparam logic [1:0] KIND_BIT  = 2'd0;
    localparam logic [1:0] KIND_WORD = 2'd1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_KIND  = 2'd1;
    localparam logic [1:0] ST_EMPTY_WR  = 2'd2;

    localparam logic [7:0] FN_READ_BITS   = 8'h01;
    localparam logic [7:0] FN_READ_WORDS  = 8'h03;
    localparam logic [7:0] FN_WRITE_COIL  = 8'h05;
    localparam logic [7:0] FN_WRITE_WORD  = 8'h06;
    localparam logic [7:0] FN_WRITE_MULTI = 8'h10;
    localparam logic [7:0] COIL_ON_HIGH   = 8'hFF;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [12:0] WRITE_REPLY_LEN = 13'd8;

    localparam int JOB_BYTES  = 7;
    localparam int QUEUE_DEPTH = 2;

    // One unit of back-end work: a run of payload bytes, optionally closed by CRC.
    typedef struct packed {
        logic                  err;
        logic [1:0]            status;
        logic [2:0]            nbytes;
        logic                  crc_init;
        logic                  crc_close;
        logic [12:0]           rlen;
        logic [JOB_BYTES-1:0][7:0] bytes;
    } job_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* src/mrf_front.sv */
// Front end: accepts request words, tracks the open multi-write frame, builds jobs.
`timescale 1ns / 1ps
`default_nettype none
module mrf_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [1:0]       mode,
    input  wire logic [7:0]       station,
    input  wire logic [1:0]       reg_kind,
    input  wire logic [15:0]      start_address,
    input  wire logic [10:0]      item_count,
    input  wire logic [15:0]      data_word,
    input  wire logic             last_word,
    output logic                  push,
    output mrf_pkg::job_t         job
);
    import mrf_pkg::*;

    logic        frame_open_reg, frame_open_next;
    logic [10:0] words_left_reg, words_left_next;
    logic        make_job;
    logic [11:0] qty;
    logic [12:0] rlen_bits, rlen_words;
    logic [15:0] addr_al;

    assign qty        = {9'd0, start_address[2:0]} + {1'b0, item_count};
    assign rlen_bits  = {4'd0, qty[11:3]} + {12'd0, |qty[2:0]} + 13'd5;
    assign rlen_words = {1'b0, item_count, 1'b0} + 13'd5;
    assign addr_al    = {start_address[15:3], 3'b000};

    always_comb
    begin
        job             = '0;
        make_job        = 1'b0;
        frame_open_next = frame_open_reg;
        words_left_next = words_left_reg;
        case (mode)
            MODE_READ, MODE_WRITE:
            begin
                frame_open_next = 1'b0;
                words_left_next = '0;
                make_job        = 1'b1;
                job.crc_init    = 1'b1;
                job.bytes[0]    = station;
                job.bytes[2]    = start_address[15:8];
                job.bytes[3]    = start_address[7:0];
                if (reg_kind != KIND_BIT && reg_kind != KIND_WORD) begin
                    job.err    = 1'b1;
                    job.status = ST_BAD_KIND;
                    job.nbytes = 3'd1;
                    job.bytes  = '0;
                end else if (mode == MODE_READ) begin
                    job.nbytes    = 3'd6;
                    job.crc_close = 1'b1;
                    if (reg_kind == KIND_BIT) begin
                        job.bytes[1] = FN_READ_BITS;
                        job.bytes[2] = addr_al[15:8];
                        job.bytes[3] = addr_al[7:0];
                        job.bytes[4] = {4'd0, qty[11:8]};
                        job.bytes[5] = qty[7:0];
                        job.rlen     = (station == 8'd0) ? 13'd0 : rlen_bits;
                    end else begin
                        job.bytes[1] = FN_READ_WORDS;
                        job.bytes[4] = {5'd0, item_count[10:8]};
                        job.bytes[5] = item_count[7:0];
                        job.rlen     = (station == 8'd0) ? 13'd0 : rlen_words;
                    end
                end else if (reg_kind == KIND_BIT) begin
                    job.nbytes    = 3'd6;
                    job.crc_close = 1'b1;
                    job.bytes[1]  = FN_WRITE_COIL;
                    job.bytes[4]  = (data_word[7:0] == 8'd1) ? COIL_ON_HIGH : 8'h00;
                    job.rlen      = (station == 8'd0) ? 13'd0 : WRITE_REPLY_LEN;
                end else if (item_count == 11'd0) begin
                    job.err    = 1'b1;
                    job.status = ST_EMPTY_WR;
                    job.nbytes = 3'd1;
                    job.bytes  = '0;
                end else if (item_count == 11'd1) begin
                    job.nbytes    = 3'd6;
                    job.crc_close = 1'b1;
                    job.bytes[1]  = FN_WRITE_WORD;
                    job.bytes[4]  = data_word[15:8];
                    job.bytes[5]  = data_word[7:0];
                    job.rlen      = (station == 8'd0) ? 13'd0 : WRITE_REPLY_LEN;
                end else begin
                    job.nbytes      = 3'd7;
                    job.bytes[1]    = FN_WRITE_MULTI;
                    job.bytes[4]    = {5'd0, item_count[10:8]};
                    job.bytes[5]    = item_count[7:0];
                    job.bytes[6]    = {item_count[6:0], 1'b0};
                    frame_open_next = 1'b1;
                    words_left_next = item_count;
                end
            end
            MODE_DATA:
            begin
                if (frame_open_reg) begin
                    if (words_left_reg != 11'd0) begin
                        job.nbytes      = 3'd2;
                        job.bytes[0]    = data_word[15:8];
                        job.bytes[1]    = data_word[7:0];
                        words_left_next = words_left_reg - 11'd1;
                        make_job        = 1'b1;
                    end
                    if (last_word) begin
                        job.crc_close   = 1'b1;
                        job.rlen        = (station == 8'd0) ? 13'd0 : WRITE_REPLY_LEN;
                        frame_open_next = 1'b0;
                        words_left_next = '0;
                        make_job        = 1'b1;
                    end
                end
            end
            default:
            begin
                make_job = 1'b0;
            end
        endcase
    end

    assign push = accept & make_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_open_reg <= 1'b0;
            words_left_reg <= '0;
        end else if (accept) begin
            frame_open_reg <= frame_open_next;
            words_left_reg <= words_left_next;
        end
    end

endmodule
`default_nettype wire

/* src/mrf_queue.sv */
// Two-entry job queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module mrf_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire mrf_pkg::job_t    push_job,
    input  wire logic             pop,
    output mrf_pkg::job_t         head,
    output logic                  not_empty,
    output logic                  full
);
    import mrf_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    job_t            entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

/* src/mrf_back.sv */
// Back end: serializes jobs into frame bytes, runs the CRC, holds the output register.
`timescale 1ns / 1ps
`default_nettype none
module mrf_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mrf_pkg::job_t    job,
    input  wire logic             job_valid,
    output logic                  job_pop,
    output logic                  byte_valid,
    input  wire logic             byte_ready,
    output logic [7:0]            frame_byte,
    output logic                  frame_end,
    output logic [12:0]           reply_length,
    output logic [1:0]            status
);
    import mrf_pkg::*;

    logic [2:0]  idx_reg;
    logic [15:0] crc_reg;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        end_reg;
    logic [12:0] rlen_reg;
    logic [1:0]  status_reg;

    logic        step;
    logic [3:0]  total;
    logic        is_last;
    logic        in_payload;
    logic        is_crc_hi;
    logic [15:0] crc_base;
    logic [7:0]  byte_next;
    logic        end_next;

    assign step       = job_valid && (!valid_reg || byte_ready);
    assign total      = {1'b0, job.nbytes} + (job.crc_close ? 4'd2 : 4'd0);
    assign is_last    = ({1'b0, idx_reg} == total - 4'd1);
    assign in_payload = (idx_reg < job.nbytes);
    assign is_crc_hi  = !in_payload && (idx_reg != job.nbytes);
    assign crc_base   = (idx_reg == 3'd0 && job.crc_init) ? CRC_INIT : crc_reg;
    assign job_pop    = step && is_last;

    always_comb
    begin
        if (in_payload)
            byte_next = job.bytes[idx_reg];
        else if (is_crc_hi)
            byte_next = crc_reg[15:8];
        else
            byte_next = crc_reg[7:0];
        end_next = job.err || is_crc_hi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            crc_reg   <= CRC_INIT;
            valid_reg <= 1'b0;
        end else begin
            if (step) begin
                valid_reg <= 1'b1;
                idx_reg   <= is_last ? 3'd0 : idx_reg + 3'd1;
                if (job.err || is_crc_hi)
                    crc_reg <= CRC_INIT;
                else if (in_payload)
                    crc_reg <= crc16_byte(crc_base, byte_next);
            end else if (byte_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step) begin
            byte_reg   <= byte_next;
            end_reg    <= end_next;
            rlen_reg   <= end_next ? job.rlen : 13'd0;
            status_reg <= job.status;
        end
    end

    assign byte_valid   = valid_reg;
    assign frame_byte   = byte_reg;
    assign frame_end    = end_reg;
    assign reply_length = rlen_reg;
    assign status       = status_reg;

endmodule
`default_nettype wire

/* src/modbus_rtu_request_framer.sv */
// Top level of the Modbus RTU master request framer.
//
// Request channel (req_valid/req_ready): one word per header or data item.
//   mode 0 read header, 1 write header, 2 data word of a function 10 write.
// Byte channel (byte_valid/byte_ready): one frame byte per transfer, in send
//   order; frame_end marks the last byte (or an error word), reply_length is
//   the expected reply size on that byte, status flags bad kind / empty write.
// The first byte of an item passes the job queue, then the output register.
// One frame byte per cycle while byte_ready stays high; a header gives up to 8
//   bytes, a data word 2 (4 with the closing CRC). The serializer sets the rate.
// A two-entry job queue sits between the front end (classification, open
//   frame tracking) and the back end (serializer, CRC, output register), so
//   the next request is taken while the current frame is still draining.
// A stalled receiver holds the output byte; the queue then fills and
//   req_ready drops until room frees up.
// Reset: no frame open, queue empty, no byte valid, CRC at its start value.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_request_framer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  station,
    input  wire logic [1:0]  reg_kind,
    input  wire logic [15:0] start_address,
    input  wire logic [10:0] item_count,
    input  wire logic [15:0] data_word,
    input  wire logic        last_word,
    output logic             byte_valid,
    input  wire logic        byte_ready,
    output logic [7:0]       frame_byte,
    output logic             frame_end,
    output logic [12:0]      reply_length,
    output logic [1:0]       status
);
    import mrf_pkg::*;

    logic  accept;
    logic  push;
    job_t  new_job;
    job_t  head_job;
    logic  q_not_empty;
    logic  q_full;
    logic  pop;

    // Front end may take a word whenever the queue has room.
    assign req_ready = !q_full;
    assign accept    = req_valid && req_ready;

    mrf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .mode          (mode),
        .station       (station),
        .reg_kind      (reg_kind),
        .start_address (start_address),
        .item_count    (item_count),
        .data_word     (data_word),
        .last_word     (last_word),
        .push          (push),
        .job           (new_job)
    );

    mrf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (new_job),
        .pop       (pop),
        .head      (head_job),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    mrf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (head_job),
        .job_valid    (q_not_empty),
        .job_pop      (pop),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .frame_byte   (frame_byte),
        .frame_end    (frame_end),
        .reply_length (reply_length),
        .status       (status)
    );

endmodule
`default_nettype wire
